### design/tno_pkg.sv
// Shared types and constants for the Telnet option negotiator.
package tno_pkg;

  // Telnet protocol bytes.
  localparam logic [7:0] B_SE   = 8'hF0;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_WONT = 8'hFC;
  localparam logic [7:0] B_DO   = 8'hFD;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_IAC  = 8'hFF;

  // Option codes that the block agrees to.
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_NOGA   = 8'd3;

  // Most results one received byte can cause, and the width of a result count.
  localparam int RES_MAX = 3;
  localparam int CNT_W   = 2;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_CONN = 1'b1;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_VERB   = 3'd1,
    PH_OPTION = 3'd2,
    PH_SUB    = 3'd3,
    PH_SUBIAC = 3'd4
  } tno_phase_t;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_REPLY  = 3'd1,
    KIND_CMD    = 3'd2,
    KIND_SUB    = 3'd3,
    KIND_SUBEND = 3'd4
  } tno_kind_t;

  // All results caused by one received byte, handed from parser to result buffer.
  typedef struct packed {
    logic                   valid;
    logic [CNT_W-1:0]       cnt;
    tno_kind_t [RES_MAX-1:0] kind;
    logic [RES_MAX-1:0][7:0] data;
    logic                   echo;
    logic                   noga;
  } tno_bundle_t;

endpackage

### design/tno_in_if.sv
// Input channel: received bytes and new-connection events.
interface tno_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

### design/tno_out_if.sv
// Result channel: data, replies, commands and sub-negotiation bytes.
interface tno_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       last;
  logic       echo_on;
  logic       noga_on;

  modport source (output valid, output out_kind, output out_byte, output last,
                  output echo_on, output noga_on, input ready);
  modport sink (input valid, input out_kind, input out_byte, input last,
                input echo_on, input noga_on, output ready);
endinterface

### design/tno_parser.sv
// Input register and IAC sequence parser with the negotiation state.
module tno_parser
  import tno_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tno_in_if.sink      in_ch,
  input  logic        buf_ready,
  output tno_bundle_t bundle
);

  logic             in_v_r;
  logic             act_r;
  logic [7:0]       c_r;

  tno_phase_t       phase_r, phase_nxt;
  logic [7:0]       verb_r, verb_nxt;
  logic             echo_r, echo_nxt;
  logic             noga_r, noga_nxt;

  logic [CNT_W-1:0] cnt;
  tno_kind_t [RES_MAX-1:0] kind;
  logic [RES_MAX-1:0][7:0] data;
  logic             known;
  logic             adv;

  assign known = (c_r == OPT_BINARY) || (c_r == OPT_ECHO) || (c_r == OPT_NOGA);

  always_comb begin
    phase_nxt = phase_r;
    verb_nxt  = verb_r;
    echo_nxt  = echo_r;
    noga_nxt  = noga_r;
    cnt       = '0;
    kind      = '{default: KIND_DATA};
    data      = {RES_MAX{c_r}};
    if (act_r == ACT_CONN) begin
      phase_nxt = PH_NORMAL;
      verb_nxt  = '0;
      echo_nxt  = 1'b0;
      noga_nxt  = 1'b0;
    end else begin
      case (phase_r)
        PH_VERB: begin
          if (c_r == B_WILL || c_r == B_WONT || c_r == B_DO || c_r == B_DONT) begin
            verb_nxt  = c_r;
            phase_nxt = PH_OPTION;
          end else if (c_r == B_IAC) begin
            cnt       = CNT_W'(1);
            phase_nxt = PH_NORMAL;
          end else if (c_r == B_SB) begin
            phase_nxt = PH_SUB;
          end else begin
            cnt       = CNT_W'(1);
            kind[0]   = KIND_CMD;
            phase_nxt = PH_NORMAL;
          end
        end
        PH_OPTION: begin
          // Only WILL and DO get an answer; WONT and DONT are taken silently.
          if (verb_r == B_WILL || verb_r == B_DO) begin
            cnt  = CNT_W'(RES_MAX);
            kind = '{default: KIND_REPLY};
            data[0] = B_IAC;
            if (known) begin
              data[1] = (verb_r == B_WILL) ? B_DO : B_WILL;
            end else begin
              data[1] = (verb_r == B_WILL) ? B_DONT : B_WONT;
            end
            if (c_r == OPT_ECHO) begin
              echo_nxt = 1'b1;
            end
            if (c_r == OPT_NOGA) begin
              noga_nxt = 1'b1;
            end
          end
          phase_nxt = PH_NORMAL;
        end
        PH_SUB: begin
          if (c_r == B_IAC) begin
            phase_nxt = PH_SUBIAC;
          end else begin
            cnt     = CNT_W'(1);
            kind[0] = KIND_SUB;
          end
        end
        PH_SUBIAC: begin
          // Any other byte after IAC here is dropped and the phase is kept.
          if (c_r == B_IAC) begin
            cnt       = CNT_W'(1);
            kind[0]   = KIND_SUB;
            phase_nxt = PH_SUB;
          end else if (c_r == B_SE) begin
            cnt       = CNT_W'(1);
            kind[0]   = KIND_SUBEND;
            phase_nxt = PH_NORMAL;
          end
        end
        default: begin
          if (c_r == B_IAC) begin
            phase_nxt = PH_VERB;
          end else begin
            cnt = CNT_W'(1);
          end
        end
      endcase
    end
  end

  // An item with no results retires even while the result buffer is busy.
  assign adv          = in_v_r && ((cnt == '0) || buf_ready);
  assign in_ch.ready  = !in_v_r || adv;

  assign bundle.valid = in_v_r && (cnt != '0);
  assign bundle.cnt   = cnt;
  assign bundle.kind  = kind;
  assign bundle.data  = data;
  assign bundle.echo  = echo_nxt;
  assign bundle.noga  = noga_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      phase_r <= PH_NORMAL;
      verb_r  <= '0;
      echo_r  <= 1'b0;
      noga_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (adv) begin
        phase_r <= phase_nxt;
        verb_r  <= verb_nxt;
        echo_r  <= echo_nxt;
        noga_r  <= noga_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      act_r <= in_ch.action;
      c_r   <= in_ch.rx_byte;
    end
  end

  a_echo_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(echo_r) |-> $past(phase_r) == PH_OPTION)
    else $error("echo flag set outside option phase");

  a_noga_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(noga_r) |-> $past(phase_r) == PH_OPTION)
    else $error("no-go-ahead flag set outside option phase");

endmodule

### design/tno_result_buf.sv
// Result buffer that hands out the results of one byte, one per cycle while the result port is ready.
module tno_result_buf
  import tno_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tno_bundle_t bundle,
  output logic        buf_ready,
  tno_out_if.source   out_ch
);

  logic [CNT_W-1:0]        rem_r;
  tno_kind_t [RES_MAX-1:0] kind_r;
  logic [RES_MAX-1:0][7:0] data_r;
  logic                    echo_r;
  logic                    noga_r;
  logic                    hs;
  logic                    ld;

  assign hs        = out_ch.valid && out_ch.ready;
  assign buf_ready = (rem_r == '0) || ((rem_r == CNT_W'(1)) && out_ch.ready);
  assign ld        = bundle.valid && buf_ready;

  assign out_ch.valid    = (rem_r != '0);
  assign out_ch.out_kind = kind_r[0];
  assign out_ch.out_byte = data_r[0];
  assign out_ch.last     = (rem_r == CNT_W'(1));
  assign out_ch.echo_on  = echo_r;
  assign out_ch.noga_on  = noga_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (ld) begin
      rem_r <= bundle.cnt;
    end else if (hs) begin
      rem_r <= rem_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      kind_r <= bundle.kind;
      data_r <= bundle.data;
      echo_r <= bundle.echo;
      noga_r <= bundle.noga;
    end else if (hs) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        kind_r[i] <= kind_r[i+1];
        data_r[i] <= data_r[i+1];
      end
    end
  end

  a_rest_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("results of an item cut short");

  a_flags_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=>
      out_ch.echo_on == $past(out_ch.echo_on) && out_ch.noga_on == $past(out_ch.noga_on))
    else $error("flags changed within one item's results");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("pending result dropped");

endmodule

### design/telnet_option_negotiator.sv
// Telnet option negotiator: IAC parser feeding a result buffer.
// The parser holds each accepted item in its input register; the results the item
// causes are loaded into the result buffer, which offers them on the result port.
// Throughput: one item per cycle while each causes at most one result and the port
// is ready; an option reply's three results hold the result port until all are taken.
// Reset (rst_n low, synchronous): normal data phase, flags clear, buffers empty.
module telnet_option_negotiator
  import tno_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tno_in_if.sink    in_ch,
  tno_out_if.source out_ch
);

  tno_bundle_t bundle;
  logic        buf_ready;

  tno_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .buf_ready (buf_ready),
    .bundle    (bundle)
  );

  tno_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .bundle    (bundle),
    .buf_ready (buf_ready),
    .out_ch    (out_ch)
  );

endmodule

### verif/tb.sv
// Self-checking testbench for the Telnet option negotiator: directed table, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tno_pkg::*;

  localparam int RAND_ITEMS  = 330;
  localparam int IDLE_PCT    = 29;
  localparam int STALL_LIMIT = 300;

  typedef struct packed {
    tno_kind_t  kind;
    logic [7:0] data;
    logic       last;
    logic       echo;
    logic       noga;
  } tno_res_t;

  // One stimulus item; when typed is set, the results are written out in the row itself.
  typedef struct packed {
    logic            act;
    logic [7:0]      b;
    logic            typed;
    logic [1:0]      n;
    tno_kind_t       kind;
    logic            echo;
    logic            noga;
    logic [0:2][7:0] d;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tno_in_if  in_ch ();
  tno_out_if out_ch ();

  telnet_option_negotiator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state as the block should hold it.
  tno_phase_t ph     = PH_NORMAL;
  logic [7:0] verb   = '0;
  logic       echo_f = 1'b0;
  logic       noga_f = 1'b0;

  tno_res_t  pending_results[$];
  stim_row_t stim_tab[$];
  stim_row_t cur_row      = '0;
  int        err_cnt      = 0;
  int        stall_cycles = 0;
  int        sent         = 0;
  bit        calm         = 1'b0;

  function automatic stim_row_t stim_row(logic act, logic [7:0] b, int n = -1,
                                         tno_kind_t k = KIND_DATA, logic e = 1'b0,
                                         logic g = 1'b0, logic [7:0] d0 = 8'h00,
                                         logic [7:0] d1 = 8'h00, logic [7:0] d2 = 8'h00);
    stim_row_t r;
    r.act   = act;
    r.b     = b;
    r.typed = (n >= 0);
    r.n     = (n >= 0) ? n[1:0] : 2'd0;
    r.kind  = k;
    r.echo  = e;
    r.noga  = g;
    r.d     = {d0, d1, d2};
    return r;
  endfunction

  // Works out the results one accepted item causes and advances the parser state.
  function automatic void parse_byte(input logic act, input logic [7:0] c, output int n,
                                     output tno_res_t [2:0] r);
    logic       known;
    logic [7:0] ans;
    n = 0;
    r = '0;
    known = (c == OPT_BINARY) || (c == OPT_ECHO) || (c == OPT_NOGA);
    if (act == ACT_CONN) begin
      ph     = PH_NORMAL;
      verb   = '0;
      echo_f = 1'b0;
      noga_f = 1'b0;
      return;
    end
    case (ph)
      PH_VERB: begin
        if (c == B_WILL || c == B_WONT || c == B_DO || c == B_DONT) begin
          verb = c;
          ph   = PH_OPTION;
        end else if (c == B_IAC) begin
          r[0] = {KIND_DATA, c, 3'b000};
          n    = 1;
          ph   = PH_NORMAL;
        end else if (c == B_SB) begin
          ph = PH_SUB;
        end else begin
          r[0] = {KIND_CMD, c, 3'b000};
          n    = 1;
          ph   = PH_NORMAL;
        end
      end
      PH_OPTION: begin
        // WONT and DONT are dropped without a reply.
        if (verb == B_WILL || verb == B_DO) begin
          if (known) ans = (verb == B_WILL) ? B_DO : B_WILL;
          else ans = (verb == B_WILL) ? B_DONT : B_WONT;
          r[0] = {KIND_REPLY, B_IAC, 3'b000};
          r[1] = {KIND_REPLY, ans, 3'b000};
          r[2] = {KIND_REPLY, c, 3'b000};
          n    = 3;
          if (c == OPT_ECHO) echo_f = 1'b1;
          if (c == OPT_NOGA) noga_f = 1'b1;
        end
        ph = PH_NORMAL;
      end
      PH_SUB: begin
        if (c == B_IAC) begin
          ph = PH_SUBIAC;
        end else begin
          r[0] = {KIND_SUB, c, 3'b000};
          n    = 1;
        end
      end
      PH_SUBIAC: begin
        // Any byte other than IAC or SE after an IAC is dropped and the phase is kept.
        if (c == B_IAC) begin
          r[0] = {KIND_SUB, B_IAC, 3'b000};
          n    = 1;
          ph   = PH_SUB;
        end else if (c == B_SE) begin
          r[0] = {KIND_SUBEND, B_SE, 3'b000};
          n    = 1;
          ph   = PH_NORMAL;
        end
      end
      default: begin
        if (c == B_IAC) begin
          ph = PH_VERB;
        end else begin
          r[0] = {KIND_DATA, c, 3'b000};
          n    = 1;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      r[i].last = (i == n - 1);
      r[i].echo = echo_f;
      r[i].noga = noga_f;
    end
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("ERROR at %0t after %0d items: %s", $realtime, sent, what);
  endtask

  task automatic send_item(input stim_row_t r);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    cur_row        = r;
    in_ch.action   = r.act;
    in_ch.rx_byte  = r.b;
    in_ch.valid    = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : monitor
    tno_res_t [2:0] pr;
    tno_res_t       want;
    int             pn;
    bit             moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        parse_byte(in_ch.action, in_ch.rx_byte, pn, pr);
        if (cur_row.typed) begin
          for (int i = 0; i < cur_row.n; i++)
            pending_results.push_back({cur_row.kind, cur_row.d[i], (i == cur_row.n - 1),
                                       cur_row.echo, cur_row.noga});
        end else begin
          for (int i = 0; i < pn; i++) pending_results.push_back(pr[i]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %h",
                                    out_ch.out_kind, out_ch.out_byte));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.out_kind !== want.kind)
            report_mismatch($sformatf("out_kind %0d, wanted %0d", out_ch.out_kind, want.kind));
          if (out_ch.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %h, wanted %h", out_ch.out_byte, want.data));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %b, wanted %b", out_ch.last, want.last));
          if (out_ch.echo_on !== want.echo)
            report_mismatch($sformatf("echo_on %b, wanted %b", out_ch.echo_on, want.echo));
          if (out_ch.noga_on !== want.noga)
            report_mismatch($sformatf("noga_on %b, wanted %b", out_ch.noga_on, want.noga));
        end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int         n_dir;
    int         pick;
    int         len;
    logic [7:0] v;
    logic [7:0] opt;

    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_BYTE;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;

    // Plain data, escaped IAC and a single-byte command.
    stim_tab.push_back(stim_row(ACT_BYTE, 8'h00, 1, KIND_DATA, 0, 0, 8'h00));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 1, KIND_DATA, 0, 0, B_IAC));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, 8'hF1, 1, KIND_CMD, 0, 0, 8'hF1));
    // Option negotiation: accepted echo, no-go-ahead and binary, refused unknown option, ignored DONT.
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_WILL, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, OPT_ECHO, 3, KIND_REPLY, 1, 0, B_IAC, B_DO, OPT_ECHO));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_DO, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, OPT_NOGA, 3, KIND_REPLY, 1, 1, B_IAC, B_WILL, OPT_NOGA));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_WILL, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, 8'hFF, 3, KIND_REPLY, 1, 1, B_IAC, B_DONT, 8'hFF));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_DONT, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, OPT_ECHO, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC));
    stim_tab.push_back(stim_row(ACT_BYTE, B_DO));
    stim_tab.push_back(stim_row(ACT_BYTE, OPT_BINARY));
    // Sub-negotiation with an escaped IAC, a dropped byte after IAC, and the end marker.
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_SB, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, 8'h00, 1, KIND_SUB, 1, 1, 8'h00));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, 8'h41, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 1, KIND_SUB, 1, 1, B_IAC));
    stim_tab.push_back(stim_row(ACT_BYTE, B_IAC, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, B_SE, 1, KIND_SUBEND, 1, 1, B_SE));
    // A new connection clears both flags.
    stim_tab.push_back(stim_row(ACT_CONN, 8'hA5, 0));
    stim_tab.push_back(stim_row(ACT_BYTE, 8'h41, 1, KIND_DATA, 0, 0, 8'h41));
    n_dir = stim_tab.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_tab[i]) send_item(stim_tab[i]);
    wait_drained();

    while (sent < n_dir + RAND_ITEMS) begin
      calm = (sent >= n_dir + 120) && (sent < n_dir + 200);
      if ($urandom_range(79) == 0) wait_drained();
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_item(stim_row(ACT_BYTE, 8'($urandom_range(254))));
      end else if (pick < 35) begin
        send_item(stim_row(ACT_BYTE, B_IAC));
        send_item(stim_row(ACT_BYTE, 8'($urandom_range(255))));
      end else if (pick < 65) begin
        case ($urandom_range(3))
          0:       opt = OPT_BINARY;
          1:       opt = OPT_ECHO;
          2:       opt = OPT_NOGA;
          default: opt = 8'($urandom_range(255));
        endcase
        send_item(stim_row(ACT_BYTE, B_IAC));
        send_item(stim_row(ACT_BYTE, 8'(B_WILL + $urandom_range(3))));
        send_item(stim_row(ACT_BYTE, opt));
      end else if (pick < 85) begin
        send_item(stim_row(ACT_BYTE, B_IAC));
        send_item(stim_row(ACT_BYTE, B_SB));
        len = $urandom_range(5);
        for (int j = 0; j < len; j++) begin
          v = 8'($urandom_range(255));
          send_item(stim_row(ACT_BYTE, v));
          // Mostly a proper escape; sometimes a stray byte after the IAC.
          if (v == B_IAC)
            send_item(stim_row(ACT_BYTE,
                               ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : B_IAC));
        end
        send_item(stim_row(ACT_BYTE, B_IAC));
        send_item(stim_row(ACT_BYTE, B_SE));
      end else if (pick < 90) begin
        send_item(stim_row(ACT_CONN, 8'($urandom_range(255))));
      end else begin
        send_item(stim_row(ACT_BYTE, 8'($urandom_range(255))));
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
